### hdl/swm_pkg.sv
// Shared types and constants of the sliding window median block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package swm_pkg;

   localparam int MAX_HALF    = 7;
   localparam int SAMPLE_BITS = 16;
   localparam int HALF_BITS   = 3;
   localparam int WIN_DEPTH   = 2 * MAX_HALF + 1;
   localparam int IDX_BITS    = $clog2(WIN_DEPTH);
   localparam int CNT_BITS    = $clog2(WIN_DEPTH + 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic remove;
      logic insert;
      logic emit;
      logic cfg_write;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic produce;
      logic out_room;
   } stat_type;

endpackage

### hdl/swm_channels.sv
// Handshake channel interfaces of the sliding window median block.
// Depends on swm_pkg for the sample type and widths.
interface swm_req_if;
   logic                valid;
   logic                ready;
   swm_pkg::sample_type sample;
   logic                last_sample;
   modport source (output valid, sample, last_sample, input ready);
   modport sink (input valid, sample, last_sample, output ready);
endinterface

interface swm_rsp_if;
   logic                valid;
   logic                ready;
   swm_pkg::sample_type median_value;
   logic                last_result;
   modport source (output valid, median_value, last_result, input ready);
   modport sink (input valid, median_value, last_result, output ready);
endinterface

interface swm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [swm_pkg::HALF_BITS-1:0] window_half;
   modport source (output valid, window_half, input ready);
   modport sink (input valid, window_half, output ready);
endinterface

### hdl/swm_controller.sv
// Sequencing state machine of the sliding window median block.
// Depends on swm_pkg for the command and status structs.
module swm_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  swm_pkg::stat_type stat,
   output swm_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_REMOVE = 4'b0010,
      ST_INSERT = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // A register write takes precedence over a sample in the idle state.
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.cfg_write = csr_valid && csr_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = stat.full ? ST_REMOVE : ST_INSERT;
            end
         end
         ST_REMOVE: begin
            cmd.remove = 1'b1;
            state_in   = ST_INSERT;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (!stat.produce || stat.out_room) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/swm_datapath.sv
// Window history, sorted cell row, counters and result register.
// Depends on swm_pkg and the result channel interface in swm_channels.sv.
module swm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_pkg::cmd_type              cmd,
   output swm_pkg::stat_type             stat,
   input  swm_pkg::sample_type           sample,
   input  logic                          last_sample,
   input  logic [swm_pkg::HALF_BITS-1:0] window_half,
   swm_rsp_if.source                     rsp
);

   localparam int Depth = swm_pkg::WIN_DEPTH;
   localparam int Ib    = swm_pkg::IDX_BITS;
   localparam int Cb    = swm_pkg::CNT_BITS;

   logic [swm_pkg::HALF_BITS-1:0] half_ff, half_in;
   swm_pkg::sample_type           sample_ff;
   logic                          last_ff;
   logic                          full_ff;
   logic                          produce_ff, produce_in;
   logic [Cb-1:0]                 fill_ff, fill_in;
   logic [Ib-1:0]                 ptr_ff, ptr_in;
   swm_pkg::sample_type           hist_ff [Depth];
   swm_pkg::sample_type           sorted_ff [Depth];
   swm_pkg::sample_type           sorted_in [Depth];
   swm_pkg::sample_type           med_ff;
   logic                          mlast_ff;
   logic                          rvalid_ff, rvalid_in;

   logic [swm_pkg::HALF_BITS-1:0] h_eff;
   logic [Cb-1:0]                 win_len;
   logic [Cb-1:0]                 win_len_m1;
   logic [Cb-1:0]                 ins_len;
   logic [Ib-1:0]                 wr_idx;
   swm_pkg::sample_type           old;
   logic [Depth-1:0]              seen;
   logic [Depth-1:0]              above;

   // A half width of zero behaves as one; values beyond the maximum saturate.
   always_comb begin
      if (half_ff == '0) begin
         h_eff = swm_pkg::HALF_BITS'(1);
      end else if (half_ff > swm_pkg::HALF_BITS'(swm_pkg::MAX_HALF)) begin
         h_eff = swm_pkg::HALF_BITS'(swm_pkg::MAX_HALF);
      end else begin
         h_eff = half_ff;
      end
   end

   assign win_len_m1 = Cb'({h_eff, 1'b0});
   assign win_len    = win_len_m1 + Cb'(1);
   assign ins_len    = full_ff ? win_len_m1 : fill_ff;
   assign wr_idx     = full_ff ? ptr_ff : fill_ff[Ib-1:0];
   assign old        = hist_ff[ptr_ff];

   // Removal: the first entry equal to the leaving sample drops out and the
   // entries above it move down one cell.
   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         seen[i] = (Cb'(i) < win_len_m1) && (sorted_ff[i] == old);
         if (i > 0) begin
            seen[i] = seen[i] || seen[i-1];
         end
      end
   end

   // Insertion: every cell compares against the new sample in parallel.
   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         above[i] = (Cb'(i) < ins_len) && (sorted_ff[i] > sample_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         sorted_in[i] = sorted_ff[i];
         if (cmd.remove) begin
            if (i < Depth - 1 && seen[i]) begin
               sorted_in[i] = sorted_ff[(i + 1) % Depth];
            end
         end else if (cmd.insert) begin
            if (i > 0 && above[(i + Depth - 1) % Depth]) begin
               sorted_in[i] = sorted_ff[(i + Depth - 1) % Depth];
            end else if (Cb'(i) == ins_len || above[i]) begin
               sorted_in[i] = sample_ff;
            end
         end
      end
   end

   always_comb begin
      half_in    = half_ff;
      fill_in    = fill_ff;
      ptr_in     = ptr_ff;
      produce_in = produce_ff;
      if (cmd.cfg_write) begin
         half_in = window_half;
         fill_in = '0;
         ptr_in  = '0;
      end else if (cmd.insert) begin
         if (full_ff) begin
            ptr_in     = (Cb'(ptr_ff) == win_len_m1) ? '0 : ptr_ff + Ib'(1);
            produce_in = 1'b1;
         end else begin
            fill_in    = fill_ff + Cb'(1);
            ptr_in     = '0;
            produce_in = (fill_ff + Cb'(1)) == win_len;
         end
      end else if (cmd.emit && last_ff) begin
         fill_in = '0;
         ptr_in  = '0;
      end
   end

   always_comb begin
      rvalid_in = rvalid_ff && !rsp.ready;
      if (cmd.emit && produce_ff) begin
         rvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff    <= swm_pkg::HALF_BITS'(1);
         fill_ff    <= '0;
         ptr_ff     <= '0;
         produce_ff <= 1'b0;
         rvalid_ff  <= 1'b0;
      end else begin
         half_ff    <= half_in;
         fill_ff    <= fill_in;
         ptr_ff     <= ptr_in;
         produce_ff <= produce_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= sample;
         last_ff   <= last_sample;
         full_ff   <= stat.full;
      end
      if (cmd.insert) begin
         hist_ff[wr_idx] <= sample_ff;
      end
      if (cmd.emit && produce_ff) begin
         med_ff   <= sorted_ff[Ib'(h_eff)];
         mlast_ff <= last_ff;
      end
      for (int i = 0; i < Depth; i++) begin
         sorted_ff[i] <= sorted_in[i];
      end
   end

   assign stat.full     = (fill_ff >= win_len);
   assign stat.produce  = produce_ff;
   assign stat.out_room = !rvalid_ff || rsp.ready;

   assign rsp.valid        = rvalid_ff;
   assign rsp.median_value = med_ff;
   assign rsp.last_result  = mlast_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= win_len)
      else $error("fill count beyond the window length");

   a_ptr_only_when_full: assert property (@(posedge clock) disable iff (reset)
      ptr_ff != '0 |-> fill_ff == win_len)
      else $error("oldest pointer moved before the window filled");

   a_result_needs_produce: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !produce_ff |=> rvalid_ff == $past(rvalid_ff && !rsp.ready))
      else $error("result raised for a sample that yields none");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && last_ff && !cmd.cfg_write |=> fill_ff == '0 && ptr_ff == '0)
      else $error("window not emptied after the last sample");

endmodule

### hdl/sliding_window_median_core.sv
// Top level of the sliding window median block: controller plus datapath.
// Depends on swm_pkg, swm_channels.sv, swm_controller and swm_datapath.
//
// Usage:
// Samples arrive as beats on req_chan (sample, last_sample) and medians
// leave as beats on rsp_chan (median_value, last_result). The half width is
// written as one beat on csr_chan; such a write also empties the window, so
// the next sample starts a new sequence. A register write is taken only while
// the block is idle and wins over a sample offered in the same cycle.
// The first 2*half samples of a sequence give no result; every later sample
// gives the median of the last 2*half+1 samples. A sample marked last_sample
// ends the sequence and empties the window.
// Steps: while the window is still filling, a sample passes through accept,
// insert into the sorted cell row and load the result register; once the window
// is full a remove step comes before the insert, as the leaving sample is first
// pulled out of the sorted row. The result beat becomes valid once the result
// register is loaded, and ready for the next sample rises in that same cycle.
// The sorted cell row is updated by parallel compares, one step a cycle.
// Reset (synchronous, active high) empties the window, sets the half width to
// one and drops any pending result. When the receiver stalls, the finished
// result waits in its register; the block then holds the following result in
// its last step and stops taking samples until that register frees up.
module sliding_window_median_core (
   input logic       clock,
   input logic       reset,
   swm_req_if.sink   req_chan,
   swm_rsp_if.source rsp_chan,
   swm_csr_if.sink   csr_chan
);

   swm_pkg::cmd_type  cmd;
   swm_pkg::stat_type stat;

   // The controller owns both ready lines and sequences the datapath.
   swm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the window, the sorted cells and the result register.
   swm_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .sample      (req_chan.sample),
      .last_sample (req_chan.last_sample),
      .window_half (csr_chan.window_half),
      .rsp         (rsp_chan)
   );

endmodule
